>>> rtl/pbd_pkg.sv
// Shared types and constants for the PackBits bitplane image decoder.
package pbd_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 320;
  localparam int MAX_PLANES_DEF     = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_PLANE  = 3'd4;

  localparam logic [9:0]  LINE_WIDTH_RST  = 10'd320;
  localparam logic [10:0] LINE_COUNT_RST  = 11'd200;
  localparam logic [3:0]  PLANE_COUNT_RST = 4'd8;
  localparam logic [10:0] MAX_LINE_COUNT  = 11'd1024;

  localparam logic [7:0] CTRL_NOP = 8'd128;

  typedef struct packed {
    logic        format_mode;
    logic [9:0]  line_width;
    logic [10:0] line_count;
    logic [3:0]  plane_count;
    logic        mask_plane;
  } cfg_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic [7:0] reps;
    logic       end_pkt;
  } cmd_t;

endpackage

>>> rtl/pbd_ifs.sv
// Handshake interfaces for the input, output and configuration channels.
interface pbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       start_of_body;
  modport source (output valid, body_byte, start_of_body, input ready);
  modport sink (input valid, body_byte, start_of_body, output ready);
endinterface

interface pbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] pixel_group;
  logic [8:0]  column;
  logic [9:0]  row;
  logic [3:0]  pixel_count;
  logic        last_in_line;
  logic        last_of_image;
  modport source (output valid, pixel_group, column, row, pixel_count, last_in_line,
                  last_of_image, input ready);
  modport sink (input valid, pixel_group, column, row, pixel_count, last_in_line,
                last_of_image, output ready);
endinterface

interface pbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 40
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/pbd_front.sv
// Front end: accepts body bytes and turns PackBits packets into run commands.
module pbd_front import pbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pbd_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);
  typedef enum logic [2:0] {
    PH_CONTROL = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  phase_t     phase, phase_next, phase_eff;
  logic [7:0] remaining, remaining_next;
  logic       take;

  assign in_ch.ready = !q_full;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_eff      = in_ch.start_of_body ? PH_CONTROL : phase;
    phase_next     = phase_eff;
    remaining_next = remaining;
    q_push         = 1'b0;
    q_cmd.restart  = in_ch.start_of_body;
    q_cmd.data     = in_ch.body_byte;
    q_cmd.reps     = 8'd0;
    q_cmd.end_pkt  = 1'b0;
    unique case (phase_eff)
      PH_LITERAL: begin
        q_push         = take;
        q_cmd.reps     = 8'd1;
        remaining_next = remaining - 8'd1;
        q_cmd.end_pkt  = (remaining <= 8'd1);
        if (remaining <= 8'd1) begin
          phase_next = PH_CONTROL;
        end
      end
      PH_REPEAT: begin
        q_push        = take;
        q_cmd.reps    = remaining;
        q_cmd.end_pkt = 1'b1;
        phase_next    = PH_CONTROL;
      end
      default: begin
        q_push = take && in_ch.start_of_body;
        if (in_ch.body_byte < CTRL_NOP) begin
          phase_next     = PH_LITERAL;
          remaining_next = in_ch.body_byte + 8'd1;
        end else if (in_ch.body_byte > CTRL_NOP) begin
          phase_next     = PH_REPEAT;
          remaining_next = 8'(9'd257 - {1'b0, in_ch.body_byte});
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CONTROL;
      remaining <= 8'd0;
    end else if (take) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end
endmodule

>>> rtl/pbd_cmd_fifo.sv
// Short command queue between the front and back ends.
module pbd_cmd_fifo import pbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);
  localparam int DEPTH = 4;

  cmd_t       slots [DEPTH];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  assign full  = (count == 3'(DEPTH));
  assign empty = (count == 3'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 2'd1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'(push && !full) - 3'(pop && !empty);
    end
  end
endmodule

>>> rtl/pbd_back.sv
// Back end: writes runs into the line store and emits finished rows.
module pbd_back import pbd_pkg::*; #(
  parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
  parameter int MAX_PLANES     = MAX_PLANES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  pbd_out_if.source  out_ch
);
  localparam int WORDS = (MAX_LINE_WIDTH + 7) / 8;
  localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_PUT_RD  = 6'b000010,
    S_PUT_WR  = 6'b000100,
    S_END     = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_WR = 6'b100000
  } state_t;

  state_t      state;
  logic [9:0]  pos, col;
  logic [3:0]  plane;
  logic [10:0] row;
  logic        done, second, end_pkt, vld_q;
  logic [7:0]  reps, data;
  logic [WORDS-1:0] valid;

  logic [9:0]  eff_w;
  logic [10:0] eff_cnt;
  logic [3:0]  eff_planes;
  logic        put_active, need_second, out_free, lil, last_row;
  logic [6:0]  word_idx;
  logic [10:0] pos_plus8, next_base;
  logic [9:0]  pos_adv;
  logic [63:0] rd_data_raw;
  logic [63:0] rd_word, new_word, grp;
  logic [9:0]  remain;
  logic [3:0]  cnt;
  logic        we, re;
  logic [AW-1:0] raddr;
  logic [10:0] q, k;

  always_comb begin
    if (cfg.line_width == 10'd0) eff_w = 10'd1;
    else if (cfg.line_width > 10'(MAX_LINE_WIDTH)) eff_w = 10'(MAX_LINE_WIDTH);
    else eff_w = cfg.line_width;
    if (cfg.line_count == 11'd0) eff_cnt = 11'd1;
    else if (cfg.line_count > MAX_LINE_COUNT) eff_cnt = MAX_LINE_COUNT;
    else eff_cnt = cfg.line_count;
    if (cfg.plane_count == 4'd0) eff_planes = 4'd1;
    else if (cfg.plane_count > 4'(MAX_PLANES)) eff_planes = 4'(MAX_PLANES);
    else eff_planes = cfg.plane_count;
  end

  assign put_active  = (pos < eff_w) && (cfg.format_mode || plane < eff_planes);
  assign word_idx    = pos[9:3] + 7'(second);
  assign next_base   = {1'b0, pos[9:3] + 7'd1, 3'b000};
  assign need_second = !cfg.format_mode && (pos[2:0] != 3'd0) && (next_base < {1'b0, eff_w});
  assign pos_plus8   = {1'b0, pos} + 11'd8;
  assign pos_adv     = cfg.format_mode ? ((pos < eff_w) ? pos + 10'd1 : pos)
                     : ((pos_plus8 >= {1'b0, eff_w}) ? eff_w : pos_plus8[9:0]);
  assign rd_word     = vld_q ? rd_data_raw : 64'd0;

  always_comb begin
    new_word = rd_word;
    for (int l = 0; l < 8; l++) begin
      q = {1'b0, word_idx, 3'(l)};
      k = q - {1'b0, pos};
      if (cfg.format_mode) begin
        if (3'(l) == pos[2:0]) new_word[8*l +: 8] = data;
      end else if (q >= {1'b0, pos} && k < 11'd8 && q < {1'b0, eff_w}
                   && data[3'd7 - k[2:0]]) begin
        new_word[8*l + plane[2:0]] = 1'b1;
      end
    end
  end

  assign remain   = eff_w - col;
  assign cnt      = (remain > 10'd8) ? 4'd8 : remain[3:0];
  assign lil      = ({1'b0, col} + 11'd8) >= {1'b0, eff_w};
  assign last_row = (row + 11'd1) >= eff_cnt;
  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    grp = 64'd0;
    for (int l = 0; l < 8; l++) begin
      if (4'(l) < cnt) grp[8*l +: 8] = rd_word[8*l +: 8];
    end
  end

  assign pop = (state == S_IDLE) && !empty;
  assign we  = (state == S_PUT_WR);
  assign re  = ((state == S_PUT_RD) && put_active) || (state == S_EMIT_RD);
  assign raddr = (state == S_EMIT_RD) ? col[AW+2:3] : word_idx[AW-1:0];

  pbd_ram #(.WIDTH(64), .DEPTH(WORDS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (word_idx[AW-1:0]),
    .wdata (new_word),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data_raw)
  );

  always_ff @(posedge clk) begin
    if (re) begin
      vld_q <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT_WR && out_free) begin
      out_ch.pixel_group   <= grp;
      out_ch.column        <= col[8:0];
      out_ch.row           <= row[9:0];
      out_ch.pixel_count   <= cnt;
      out_ch.last_in_line  <= lil;
      out_ch.last_of_image <= lil && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= 10'd0;
      col          <= 10'd0;
      plane        <= 4'd0;
      row          <= 11'd0;
      done         <= 1'b0;
      second       <= 1'b0;
      reps         <= 8'd0;
      data         <= 8'd0;
      end_pkt      <= 1'b0;
      valid        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      out_ch.valid <= ((state == S_EMIT_WR) && out_free) || (out_ch.valid && !out_ch.ready);
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            reps    <= head.reps;
            data    <= head.data;
            end_pkt <= head.end_pkt;
            second  <= 1'b0;
            if (head.restart) begin
              pos   <= 10'd0;
              plane <= 4'd0;
              row   <= 11'd0;
              done  <= 1'b0;
              valid <= '0;
            end
            if (head.restart || !done) begin
              if (head.reps != 8'd0) state <= S_PUT_RD;
              else if (head.end_pkt) state <= S_END;
            end
          end
        end
        S_PUT_RD: begin
          if (put_active) begin
            state <= S_PUT_WR;
          end else begin
            pos  <= pos_adv;
            reps <= reps - 8'd1;
            if (reps == 8'd1) state <= end_pkt ? S_END : S_IDLE;
          end
        end
        S_PUT_WR: begin
          valid[word_idx[AW-1:0]] <= 1'b1;
          if (need_second && !second) begin
            second <= 1'b1;
            state  <= S_PUT_RD;
          end else begin
            second <= 1'b0;
            pos    <= pos_adv;
            reps   <= reps - 8'd1;
            if (reps == 8'd1) state <= end_pkt ? S_END : S_IDLE;
            else state <= S_PUT_RD;
          end
        end
        S_END: begin
          if (pos < eff_w) begin
            state <= S_IDLE;
          end else begin
            pos <= 10'd0;
            if (!cfg.format_mode && (plane + 4'd1) < (eff_planes + 4'(cfg.mask_plane))) begin
              plane <= plane + 4'd1;
              state <= S_IDLE;
            end else begin
              col   <= 10'd0;
              state <= S_EMIT_RD;
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (out_free) begin
            if (lil) begin
              row   <= row + 11'd1;
              plane <= 4'd0;
              valid <= '0;
              done  <= last_row;
              state <= S_IDLE;
            end else begin
              col   <= col + 10'd8;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/packbits_bitplane_image_decoder_top.sv
// Top level of the PackBits image body decoder with its configuration registers.
//
// The block takes compressed image body bytes on in_ch and returns decoded rows
// on out_ch as groups of up to eight 8-bit pixels, left to right, with the
// column, row, pixel count and end-of-row and end-of-image flags of each group.
// Registers are to be written on cfg only while the block is idle, which the
// block itself does not enforce; cfg is always ready. The front end takes one
// byte per cycle while its four-entry command queue has room. The back end
// takes each command from the queue, then for each stored byte reads the line
// store word and writes it back, twice when a bitplane byte spans two store
// words; a byte past the row end or in the mask plane skips the store. When a
// packet end finds the row full, it moves to the next plane or emits the row,
// group by group from the store. Input stalls while the queue is full.
// The line store has one valid bit per 8-pixel word, so reset and start_of_body
// clear it at once with no sweep. Reset returns the registers to their defaults
// and the decoder to row zero waiting for a control byte.
// When out_ch stalls, the output register holds its word and the back end waits;
// the front end keeps queueing bytes until the queue fills.
module packbits_bitplane_image_decoder_top import pbd_pkg::*; #(
  parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF,
  parameter int MAX_PLANES     = MAX_PLANES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pbd_in_if.sink     in_ch,
  pbd_out_if.source  out_ch,
  pbd_cfg_if.sink    cfg
);
  cfg_t cfg_regs;
  cmd_t push_cmd, head;
  logic q_push, q_full, q_pop, q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.format_mode <= 1'b0;
      cfg_regs.line_width  <= LINE_WIDTH_RST;
      cfg_regs.line_count  <= LINE_COUNT_RST;
      cfg_regs.plane_count <= PLANE_COUNT_RST;
      cfg_regs.mask_plane  <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FORMAT_MODE: cfg_regs.format_mode <= cfg.data[0];
        REG_LINE_WIDTH:  cfg_regs.line_width  <= cfg.data[9:0];
        REG_LINE_COUNT:  cfg_regs.line_count  <= cfg.data;
        REG_PLANE_COUNT: cfg_regs.plane_count <= cfg.data[3:0];
        REG_MASK_PLANE:  cfg_regs.mask_plane  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  pbd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  pbd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  pbd_back #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_PLANES     (MAX_PLANES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .head   (head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );
endmodule

>>> tb/tb.sv
// Self-checking testbench for the PackBits bitplane image decoder top level.
module tb;
  import pbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {WAIT_CTRL, IN_LITERAL, IN_REPEAT} pkt_phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_of_body;
  } body_word_t;

  typedef struct packed {
    logic [63:0] pixel_group;
    logic [8:0]  column;
    logic [9:0]  row;
    logic [3:0]  pixel_count;
    logic        last_in_line;
    logic        last_of_image;
  } group_word_t;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pbd_in_if  in_ch();
  pbd_out_if out_ch();
  pbd_cfg_if cfg_ch();

  packbits_bitplane_image_decoder_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  body_word_t  body_q[$];
  group_word_t group_q[$];
  int          send_idle_pct = 27;
  int          recv_idle_pct = 76;
  int          hold_len = 0;
  int          hold_left = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          mismatches = 0;
  longint      cycles = 0;

  // Decoder state as predicted by the testbench.
  logic       m_chunky;
  logic [9:0] m_width;
  logic [10:0] m_rows;
  logic [3:0] m_planes;
  logic       m_mask;
  pkt_phase_t m_phase;
  logic [7:0] m_left;
  logic [3:0] m_plane;
  logic [9:0] m_pos;
  logic [10:0] m_row;
  logic [7:0] m_line[MAX_LINE_WIDTH_DEF];
  logic       m_done;

  function automatic int eff_width();
    if (m_width == 0) return 1;
    if (m_width > MAX_LINE_WIDTH_DEF) return MAX_LINE_WIDTH_DEF;
    return int'(m_width);
  endfunction

  function automatic int eff_rows();
    if (m_rows == 0) return 1;
    if (m_rows > MAX_LINE_COUNT) return int'(MAX_LINE_COUNT);
    return int'(m_rows);
  endfunction

  function automatic int eff_planes();
    if (m_planes == 0) return 1;
    if (m_planes > MAX_PLANES_DEF) return MAX_PLANES_DEF;
    return int'(m_planes);
  endfunction

  task automatic restart_image();
    m_phase = WAIT_CTRL;
    m_left = 8'd0;
    m_plane = 4'd0;
    m_pos = 10'd0;
    m_row = 11'd0;
    m_done = 1'b0;
    foreach (m_line[i]) m_line[i] = 8'd0;
  endtask

  task automatic place_byte(input logic [7:0] b);
    int w;
    int p;
    w = eff_width();
    if (m_chunky) begin
      if (m_pos < w) begin
        m_line[m_pos] = b;
        m_pos = m_pos + 10'd1;
      end
      return;
    end
    if (m_plane < eff_planes()) begin
      for (int k = 0; k < 8; k++) begin
        p = m_pos + k;
        if (p < w && b[7-k]) m_line[p][m_plane] = 1'b1;
      end
    end
    m_pos = 10'((m_pos + 8 >= w) ? w : m_pos + 8);
  endtask

  task automatic close_packet();
    int w;
    int cnt;
    bit last_row;
    group_word_t g;
    w = eff_width();
    if (m_pos < w) return;
    m_pos = 10'd0;
    if (!m_chunky) begin
      m_plane = m_plane + 4'd1;
      if (m_plane < eff_planes() + m_mask) return;
    end
    last_row = (m_row + 1 >= eff_rows());
    for (int c = 0; c < w; c += 8) begin
      cnt = (w - c > 8) ? 8 : w - c;
      g = '0;
      for (int i = 0; i < cnt; i++) g.pixel_group[8*i +: 8] = m_line[c+i];
      g.column = c[8:0];
      g.row = m_row[9:0];
      g.pixel_count = cnt[3:0];
      g.last_in_line = (c + 8 >= w);
      g.last_of_image = g.last_in_line && last_row;
      group_q.push_back(g);
    end
    m_row = m_row + 11'd1;
    m_plane = 4'd0;
    foreach (m_line[i]) m_line[i] = 8'd0;
    if (m_row >= eff_rows()) m_done = 1'b1;
  endtask

  task automatic decode_word(input body_word_t wd);
    if (wd.start_of_body) restart_image();
    if (m_done) return;
    case (m_phase)
      IN_LITERAL: begin
        place_byte(wd.body_byte);
        if (m_left > 0) m_left = m_left - 8'd1;
        if (m_left == 0) begin
          m_phase = WAIT_CTRL;
          close_packet();
        end
      end
      IN_REPEAT: begin
        for (int i = 0; i < m_left; i++) place_byte(wd.body_byte);
        m_left = 8'd0;
        m_phase = WAIT_CTRL;
        close_packet();
      end
      default: begin
        if (wd.body_byte < CTRL_NOP) begin
          m_phase = IN_LITERAL;
          m_left = wd.body_byte + 8'd1;
        end else if (wd.body_byte > CTRL_NOP) begin
          m_phase = IN_REPEAT;
          m_left = 8'(9'd257 - {1'b0, wd.body_byte});
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        decode_word('{in_ch.body_byte, in_ch.start_of_body});
      if (!in_ch.valid || in_ch.ready) begin
        if (body_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.body_byte <= body_q[0].body_byte;
          in_ch.start_of_body <= body_q[0].start_of_body;
          void'(body_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_go && !hold_done && hold_left == 0) begin
        hold_left <= hold_len;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    group_word_t got;
    group_word_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pixel_group, out_ch.column, out_ch.row, out_ch.pixel_count,
                out_ch.last_in_line, out_ch.last_of_image};
        if (group_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", got);
        end else begin
          want = group_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && !(hold_go && !hold_done) &&
                      ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_word(input logic [7:0] b, input logic s);
    body_q.push_back('{b, s});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FORMAT_MODE: m_chunky = val[0];
      REG_LINE_WIDTH:  m_width = val[9:0];
      REG_LINE_COUNT:  m_rows = val;
      REG_PLANE_COUNT: m_planes = val[3:0];
      REG_MASK_PLANE:  m_mask = val[0];
      default: ;
    endcase
  endtask

  task automatic make_traffic(input int n);
    int added;
    int kind;
    int len;
    added = 0;
    add_word(8'($urandom_range(255)), 1'b1);
    while (added < n) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        add_word(8'($urandom_range(255)), 1'b0);
        added++;
      end else if (kind < 10) begin
        add_word(8'($urandom_range(255)), 1'b1);
        added++;
      end else if (kind < 14) begin
        add_word(CTRL_NOP, 1'b0);
        added++;
      end else if (kind < 55) begin
        len = ($urandom_range(19) == 0) ? 127 : $urandom_range(12);
        add_word(8'(len), 1'b0);
        for (int i = 0; i <= len; i++) add_word(8'($urandom_range(255)), 1'b0);
        added += len + 2;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(129, 255) : $urandom_range(240, 255);
        add_word(8'(len), 1'b0);
        add_word(8'($urandom_range(255)), 1'b0);
        added += 2;
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk); while (body_q.size() != 0 || in_ch.valid || group_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int cfg_tab[6][5];
    in_ch.valid = 1'b0;
    in_ch.body_byte = 8'd0;
    in_ch.start_of_body = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FORMAT_MODE;
    cfg_ch.data = 11'd0;
    m_chunky = 1'b0;
    m_width = LINE_WIDTH_RST;
    m_rows = LINE_COUNT_RST;
    m_planes = PLANE_COUNT_RST;
    m_mask = 1'b0;
    restart_image();
    cfg_tab = '{'{1, 8, 3, 1, 0}, '{0, 17, 4, 3, 1}, '{1, 1, 0, 2, 1},
                '{0, 0, 2047, 0, 0}, '{1, 1023, 2, 15, 0}, '{0, 40, 1024, 15, 1}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_word(8'd255, 1'b1); add_word(8'hFF, 1'b0);
    add_word(8'd129, 1'b0); add_word(8'hAA, 1'b0);
    add_word(CTRL_NOP, 1'b0);
    add_word(8'd0, 1'b0);   add_word(8'h00, 1'b0);
    add_word(8'd129, 1'b0); add_word(8'h55, 1'b0);
    for (int p = 2; p < 8; p++) begin
      add_word(8'd129, 1'b0);
      add_word(8'($urandom_range(255)), 1'b0);
    end
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 27;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_FORMAT_MODE, 11'(cfg_tab[ph][0]));
      write_reg(REG_LINE_WIDTH, 11'(cfg_tab[ph][1]));
      write_reg(REG_LINE_COUNT, 11'(cfg_tab[ph][2]));
      write_reg(REG_PLANE_COUNT, 11'(cfg_tab[ph][3]));
      write_reg(REG_MASK_PLANE, 11'(cfg_tab[ph][4]));
      make_traffic(ph == 4 ? 130 : 65);
      if (ph == 1) begin
        hold_len = 400;
        hold_go = 1'b1;
      end
      settle();
    end

    mismatches += group_q.size();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> packbits_bitplane_image_decoder_top.f
rtl/pbd_pkg.sv
rtl/pbd_ifs.sv
rtl/pbd_ram.sv
rtl/pbd_front.sv
rtl/pbd_cmd_fifo.sv
rtl/pbd_back.sv
rtl/packbits_bitplane_image_decoder_top.sv
tb/tb.sv
